// ===== sv/mdks_pkg.sv =====
`timescale 1ns / 1ps

package mdks_pkg;

  localparam int NUM_DIGITS = 11;
  localparam int DIG_W      = 4;
  localparam int WORD_W     = 16;
  localparam int SEL_W      = 11;
  localparam int KEY_W      = 4;
  localparam int MODE_WORD  = NUM_DIGITS - 1;
  localparam int IND_WORD   = NUM_DIGITS - 2;

  localparam logic [WORD_W-1:0] DOT_BIT  = 16'h4000;
  localparam logic [7:0]        CHAR_DOT = 8'h2E;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_PUT_CHAR   = 3'd1,
    CMD_SET_MODE   = 3'd2,
    CMD_OR_MODE    = 3'd3,
    CMD_CLEAR_MODE = 3'd4,
    CMD_SET_IND    = 3'd5,
    CMD_TOGGLE_IND = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  // Screen update request handed from the control stage to the screen store.
  typedef struct packed {
    logic              en;
    cmd_t              command;
    logic [7:0]        char_code;
    logic [3:0]        position;
    logic [WORD_W-1:0] mode_bits;
    logic              indicator_on;
  } scr_upd_t;

  // Character generator for the 14-segment digits plus the dot segment.
  function automatic logic [WORD_W-1:0] glyph(input logic [7:0] c);
    logic [WORD_W-1:0] g;
    unique case (c)
      8'h6D: g = 16'h920C;  // m
      8'h2B: g = 16'h9240;  // +
      8'h2D: g = 16'h8200;  // -
      8'h6F: g = 16'h8E20;  // o
      8'h67: g = 16'h8232;  // g
      8'h2E: g = 16'h4000;  // .
      8'h64: g = 16'hA20E;  // d
      8'h3F: g = 16'h1222;  // ?
      8'h30: g = 16'h203E;
      8'h31: g = 16'h1040;
      8'h32: g = 16'hA226;
      8'h33: g = 16'h222A;
      8'h34: g = 16'h821A;
      8'h35: g = 16'hA238;
      8'h36: g = 16'hA23C;
      8'h37: g = 16'h002A;
      8'h38: g = 16'hA23E;
      8'h39: g = 16'hA23A;
      8'h41: g = 16'h823E;
      8'h42: g = 16'h326A;
      8'h43: g = 16'h2034;
      8'h44: g = 16'h306A;
      8'h45: g = 16'hA034;
      8'h46: g = 16'h8034;
      8'h47: g = 16'h223C;
      8'h48: g = 16'h821E;
      8'h49: g = 16'h3060;
      8'h4A: g = 16'h200E;
      8'h4B: g = 16'h8914;
      8'h4C: g = 16'h2014;
      8'h4D: g = 16'h0C1E;
      8'h4E: g = 16'h051E;
      8'h4F: g = 16'h203E;
      8'h50: g = 16'h8236;
      8'h51: g = 16'h213E;
      8'h52: g = 16'h8336;
      8'h53: g = 16'hA238;
      8'h54: g = 16'h1060;
      8'h55: g = 16'h201E;
      8'h56: g = 16'h0894;
      8'h57: g = 16'h019E;
      8'h58: g = 16'h0D80;
      8'h59: g = 16'hA21A;
      8'h5A: g = 16'h28A0;
      default: g = '0;
    endcase
    return g;
  endfunction

  // Keypad matrix: the driven digit is the column, the return line the row.
  function automatic logic [KEY_W-1:0] key_of(input logic [1:0] ret,
                                               input logic [DIG_W-1:0] d);
    logic [KEY_W-1:0] k;
    k = '0;
    if (ret == 2'd1 && d >= 4'd1 && d <= 4'd4) begin
      k = d;
    end else if (ret == 2'd2 && d >= 4'd1 && d <= 4'd4) begin
      k = d + 4'd4;
    end else if (ret == 2'd3 && d >= 4'd1 && d <= 4'd5) begin
      k = d + 4'd8;
    end
    return k;
  endfunction

endpackage

// ===== sv/mdks_if.sv =====
`timescale 1ns / 1ps

// Command channel into the scanner.
interface mdks_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  char_code;
  logic [3:0]  position;
  logic [15:0] mode_bits;
  logic        indicator_on;
  logic [1:0]  key_return;

  modport source (output valid, command, char_code, position, mode_bits,
                  indicator_on, key_return, input ready);
  modport sink (input valid, command, char_code, position, mode_bits,
                indicator_on, key_return, output ready);
endinterface

// Result channel out of the scanner.
interface mdks_res_if;
  logic        valid;
  logic        ready;
  logic        drive_valid;
  logic [15:0] segments;
  logic [10:0] digit_select_n;
  logic [3:0]  key_code;

  modport source (output valid, drive_valid, segments, digit_select_n, key_code,
                  input ready);
  modport sink (input valid, drive_valid, segments, digit_select_n, key_code,
                output ready);
endinterface

// ===== sv/mdks_screen.sv =====
`timescale 1ns / 1ps

module mdks_screen (
  input  logic                           clk,
  input  logic                           rst,
  input  mdks_pkg::scr_upd_t             upd,
  input  logic [mdks_pkg::DIG_W-1:0]     rd_addr,
  output logic [mdks_pkg::WORD_W-1:0]    rd_data
);
  import mdks_pkg::*;

  logic [WORD_W-1:0] words      [NUM_DIGITS];
  logic [WORD_W-1:0] words_next [NUM_DIGITS];
  logic              pos_ok;
  logic              dot_merge;
  logic [WORD_W-1:0] new_glyph;
  logic [WORD_W-1:0] old_dot;

  assign pos_ok    = upd.position < DIG_W'(MODE_WORD);
  assign dot_merge = (upd.char_code == CHAR_DOT) && (upd.position != '0);
  assign new_glyph = glyph(upd.char_code);
  assign old_dot   = words[IND_WORD] & DOT_BIT;

  // Each word decides its own next value, so no word is read at a chosen address
  // except for the display read.
  always_comb begin
    for (int j = 0; j < NUM_DIGITS; j++) begin
      words_next[j] = words[j];
      if (upd.en) begin
        unique case (upd.command)
          CMD_PUT_CHAR: begin
            if (pos_ok) begin
              if (dot_merge && (upd.position == DIG_W'(j + 1))) begin
                words_next[j] = words[j] | DOT_BIT;
              end else if (!dot_merge && (upd.position == DIG_W'(j))) begin
                words_next[j] = new_glyph;
              end
              if (j == IND_WORD) begin
                words_next[j] = words_next[j] | old_dot;
              end
            end
          end
          CMD_SET_MODE: begin
            if (j == MODE_WORD) words_next[j] = upd.mode_bits;
          end
          CMD_OR_MODE: begin
            if (j == MODE_WORD) words_next[j] = words[j] | upd.mode_bits;
          end
          CMD_CLEAR_MODE: begin
            if (j == MODE_WORD) words_next[j] = words[j] & ~upd.mode_bits;
          end
          CMD_SET_IND: begin
            if (j == IND_WORD) begin
              words_next[j] = upd.indicator_on ? (words[j] | DOT_BIT)
                                               : (words[j] & ~DOT_BIT);
            end
          end
          CMD_TOGGLE_IND: begin
            if (j == IND_WORD) words_next[j] = words[j] ^ DOT_BIT;
          end
          CMD_CLEAR: begin
            words_next[j] = (j == IND_WORD) ? old_dot : '0;
          end
          CMD_TICK: begin
            words_next[j] = words[j];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_DIGITS; j++) begin
      if (rst) begin
        words[j] <= '0;
      end else begin
        words[j] <= words_next[j];
      end
    end
  end

  // The scan stage only presents addresses below NUM_DIGITS.
  assign rd_data = words[rd_addr];

endmodule

// ===== sv/mdks_scan.sv =====
`timescale 1ns / 1ps

module mdks_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [1:0]                    key_return,
  output logic [mdks_pkg::DIG_W-1:0]    digit,
  output logic [mdks_pkg::SEL_W-1:0]    select_n,
  output logic [mdks_pkg::KEY_W-1:0]    key
);
  import mdks_pkg::*;

  logic [DIG_W-1:0] scan_digit;
  logic [SEL_W-1:0] one_hot;

  // A stale index past the last digit restarts the scan at digit 0.
  assign digit    = (scan_digit >= DIG_W'(NUM_DIGITS)) ? '0 : scan_digit;
  assign one_hot  = {{(SEL_W-1){1'b0}}, 1'b1} << digit;
  assign select_n = ~one_hot;
  assign key      = key_of(key_return, digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_digit <= '0;
    end else if (step) begin
      scan_digit <= digit + DIG_W'(1);
    end
  end

endmodule

// ===== sv/mux_display_keypad_scanner.sv =====
`timescale 1ns / 1ps

// Multiplexed 14-segment display and keypad scanner.
// Words arrive on the cmd channel: a tick drives the next digit, the other
// commands place characters, change the mode annunciators or the indicator
// dot, or clear the screen. Every word gives exactly one word on the res
// channel; only a tick's result has drive_valid set and carries the digit's
// segments, the active-low one-cold select and the decoded keypad code.
// A command word is registered in an input stage, then the screen update and
// the drive decode happen in one pass into the result register, so the
// result is presented from the result register once its word leaves the
// input stage; one word can be taken every cycle while the receiver keeps
// res.ready high. A screen write is visible to the very next tick.
// When the receiver stalls, the result register holds and the input stage
// still takes one more word; after that cmd.ready drops until res.ready
// returns. Synchronous reset empties both stages, blanks all screen words
// and restarts the scan at digit 0.
module mux_display_keypad_scanner (
  input logic       clk,
  input logic       rst,
  mdks_cmd_if.sink  cmd,
  mdks_res_if.source res
);
  import mdks_pkg::*;

  // Input stage.
  logic        s1_valid;
  cmd_t        s1_command;
  logic [7:0]  s1_char_code;
  logic [3:0]  s1_position;
  logic [15:0] s1_mode_bits;
  logic        s1_indicator_on;
  logic [1:0]  s1_key_return;

  // Result register.
  logic        o_valid;
  logic        o_drive_valid;
  logic [15:0] o_segments;
  logic [10:0] o_digit_select_n;
  logic [3:0]  o_key_code;

  logic               advance;
  logic               is_tick;
  scr_upd_t           upd;
  logic [DIG_W-1:0]   digit;
  logic [SEL_W-1:0]   select_n;
  logic [KEY_W-1:0]   key;
  logic [WORD_W-1:0]  rd_data;

  // The input stage moves on whenever the result register is empty or is
  // being emptied in this cycle.
  assign advance   = s1_valid && (!o_valid || res.ready);
  assign cmd.ready = !s1_valid || advance;
  assign is_tick   = (s1_command == CMD_TICK);

  assign upd.en           = advance && !is_tick;
  assign upd.command      = s1_command;
  assign upd.char_code    = s1_char_code;
  assign upd.position     = s1_position;
  assign upd.mode_bits    = s1_mode_bits;
  assign upd.indicator_on = s1_indicator_on;

  mdks_screen u_screen (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd),
    .rd_addr (digit),
    .rd_data (rd_data)
  );

  mdks_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (advance && is_tick),
    .key_return (s1_key_return),
    .digit      (digit),
    .select_n   (select_n),
    .key        (key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (cmd.ready) s1_valid <= cmd.valid;
      if (advance) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_command      <= cmd_t'(cmd.command);
      s1_char_code    <= cmd.char_code;
      s1_position     <= cmd.position;
      s1_mode_bits    <= cmd.mode_bits;
      s1_indicator_on <= cmd.indicator_on;
      s1_key_return   <= cmd.key_return;
    end
    if (advance) begin
      o_drive_valid    <= is_tick;
      o_segments       <= is_tick ? rd_data : '0;
      o_digit_select_n <= is_tick ? select_n : '1;
      o_key_code       <= is_tick ? key : '0;
    end
  end

  assign res.valid          = o_valid;
  assign res.drive_valid    = o_drive_valid;
  assign res.segments       = o_segments;
  assign res.digit_select_n = o_digit_select_n;
  assign res.key_code       = o_key_code;

  // A tick drives exactly one digit.
  a_one_cold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.drive_valid) |-> ($countones(~res.digit_select_n) == 1))
    else $error("digit drive is not one-cold");

  // A non-tick result drives nothing.
  a_idle_drive: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.drive_valid) |->
      (res.digit_select_n == '1 && res.segments == '0 && res.key_code == '0))
    else $error("non-tick result drives the display");

  // A tick leaving the input stage shows up as a drive result next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (advance && is_tick) |=> (res.valid && res.drive_valid))
    else $error("tick did not produce a drive result");

  // Keys are only reported on the keypad columns.
  a_key_column: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.key_code != '0) |->
      (res.digit_select_n[0] && res.key_code <= 4'd13))
    else $error("key reported outside the keypad columns");

endmodule

// ===== test/tb_mux_display_keypad_scanner.sv =====
`timescale 1ns / 1ps

// Testbench for the multiplexed display and keypad scanner.
module tb_mux_display_keypad_scanner;
  import mdks_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_WORDS = 1650;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // One command word as it travels on the cmd channel.
  typedef struct packed {
    cmd_t              command;
    logic [7:0]        char_code;
    logic [3:0]        position;
    logic [WORD_W-1:0] mode_bits;
    logic              indicator_on;
    logic [1:0]        key_return;
  } cmd_word_t;

  // One result word as it leaves on the res channel.
  typedef struct packed {
    logic              drive_valid;
    logic [WORD_W-1:0] segments;
    logic [SEL_W-1:0]  digit_select_n;
    logic [KEY_W-1:0]  key_code;
  } drive_word_t;

  // The scoreboard keeps its own copy of the screen and the scan position.
  // Every accepted command word is run through that copy right away, and the
  // result word it must produce is queued until the block delivers it.
  class screen_scoreboard;
    logic [WORD_W-1:0] screen[NUM_DIGITS];
    logic [DIG_W-1:0]  scan_pos;
    logic [WORD_W-1:0] letter_segs[26];
    logic [WORD_W-1:0] numeral_segs[10];
    drive_word_t       expected_drives[$];
    int                errors;

    function new();
      letter_segs = '{16'h823E, 16'h326A, 16'h2034, 16'h306A, 16'hA034, 16'h8034,
                      16'h223C, 16'h821E, 16'h3060, 16'h200E, 16'h8914, 16'h2014,
                      16'h0C1E, 16'h051E, 16'h203E, 16'h8236, 16'h213E, 16'h8336,
                      16'hA238, 16'h1060, 16'h201E, 16'h0894, 16'h019E, 16'h0D80,
                      16'hA21A, 16'h28A0};
      numeral_segs = '{16'h203E, 16'h1040, 16'hA226, 16'h222A, 16'h821A,
                       16'hA238, 16'hA23C, 16'h002A, 16'hA23E, 16'hA23A};
      foreach (screen[i]) screen[i] = '0;
      scan_pos = '0;
      errors = 0;
    endfunction

    // Segment pattern of a character; anything not in the table is blank.
    function logic [WORD_W-1:0] segs_of(logic [7:0] c);
      case (c)
        "m": return 16'h920C;
        "+": return 16'h9240;
        "-": return 16'h8200;
        "o": return 16'h8E20;
        "g": return 16'h8232;
        ".": return DOT_BIT;
        "d": return 16'hA20E;
        "?": return 16'h1222;
        default: begin
          if (c >= "0" && c <= "9") return numeral_segs[c - "0"];
          if (c >= "A" && c <= "Z") return letter_segs[c - "A"];
          return '0;
        end
      endcase
    endfunction

    // The driven digit is the keypad column, the return line picks the row.
    function logic [KEY_W-1:0] key_for(logic [1:0] ret, logic [DIG_W-1:0] d);
      if (ret == 2'd1 && d >= 1 && d <= 4) return d;
      if (ret == 2'd2 && d >= 1 && d <= 4) return d + 4'd4;
      if (ret == 2'd3 && d >= 1 && d <= 5) return d + 4'd8;
      return '0;
    endfunction

    function void note_command(cmd_word_t w);
      drive_word_t       r;
      logic [WORD_W-1:0] dot;
      logic [DIG_W-1:0]  d;
      dot = screen[IND_WORD] & DOT_BIT;
      r.drive_valid    = 1'b0;
      r.segments       = '0;
      r.digit_select_n = '1;
      r.key_code       = '0;
      case (w.command)
        CMD_TICK: begin
          // A scan position past the last digit restarts at digit 0.
          d = (scan_pos >= NUM_DIGITS) ? '0 : scan_pos;
          r.drive_valid    = 1'b1;
          r.segments       = screen[d];
          r.digit_select_n = ~(SEL_W'(1) << d);
          r.key_code       = key_for(w.key_return, d);
          scan_pos         = d + 4'd1;
        end
        CMD_PUT_CHAR: begin
          if (w.position < NUM_DIGITS - 1) begin
            // A dot after the first digit lights the dot of the digit before.
            if (w.char_code == CHAR_DOT && w.position > 0) begin
              screen[w.position - 1] = screen[w.position - 1] | DOT_BIT;
            end else begin
              screen[w.position] = segs_of(w.char_code);
            end
            screen[IND_WORD] = screen[IND_WORD] | dot;
          end
        end
        CMD_SET_MODE:   screen[MODE_WORD] = w.mode_bits;
        CMD_OR_MODE:    screen[MODE_WORD] = screen[MODE_WORD] | w.mode_bits;
        CMD_CLEAR_MODE: screen[MODE_WORD] = screen[MODE_WORD] & ~w.mode_bits;
        CMD_SET_IND: begin
          if (w.indicator_on) screen[IND_WORD] = screen[IND_WORD] | DOT_BIT;
          else screen[IND_WORD] = screen[IND_WORD] & ~DOT_BIT;
        end
        CMD_TOGGLE_IND: screen[IND_WORD] = screen[IND_WORD] ^ DOT_BIT;
        default: begin
          // Clear blanks everything but keeps the indicator dot.
          foreach (screen[i]) screen[i] = '0;
          screen[IND_WORD] = dot;
        end
      endcase
      expected_drives.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(drive_word_t act);
      drive_word_t exp;
      if (expected_drives.size() == 0) begin
        $display("%0t: result word with none expected, actual %h", $time, act);
        errors++;
        return;
      end
      exp = expected_drives.pop_front();
      compare_field("drive_valid", exp.drive_valid, act.drive_valid);
      compare_field("segments", exp.segments, act.segments);
      compare_field("digit_select_n", exp.digit_select_n, act.digit_select_n);
      compare_field("key_code", exp.key_code, act.key_code);
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  mdks_cmd_if cmd_if ();
  mdks_res_if res_if ();

  mux_display_keypad_scanner u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  screen_scoreboard sb;

  // While calm is set, neither side idles. A hold request makes the receiver
  // refuse results for a long stretch so the block fills up.
  bit          calm;
  bit          hold_request;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake must not run forever.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver side. The hold-off is counted here, independent of the sender,
  // which keeps offering words the whole time.
  initial begin
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // Monitors. Signals are read right after the edge, so they hold the values
  // that the block saw at that edge.
  initial begin
    cmd_word_t w;
    forever begin
      @(posedge clk);
      if (!rst && cmd_if.valid && cmd_if.ready) begin
        w.command      = cmd_t'(cmd_if.command);
        w.char_code    = cmd_if.char_code;
        w.position     = cmd_if.position;
        w.mode_bits    = cmd_if.mode_bits;
        w.indicator_on = cmd_if.indicator_on;
        w.key_return   = cmd_if.key_return;
        sb.note_command(w);
      end
    end
  end

  initial begin
    drive_word_t r;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        r.drive_valid    = res_if.drive_valid;
        r.segments       = res_if.segments;
        r.digit_select_n = res_if.digit_select_n;
        r.key_code       = res_if.key_code;
        sb.check_result(r);
      end
    end
  end

  function automatic cmd_word_t make_word(cmd_t c, logic [7:0] ch, logic [3:0] pos,
                                          logic [15:0] mode, logic ind, logic [1:0] ret);
    cmd_word_t w;
    w.command      = c;
    w.char_code    = ch;
    w.position     = pos;
    w.mode_bits    = mode;
    w.indicator_on = ind;
    w.key_return   = ret;
    return w;
  endfunction

  // Offers one word and returns at the edge where it is accepted. A random
  // idle cycle with valid low may come first.
  task automatic send_word(cmd_word_t w);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 11) gap = 1;
    repeat (gap) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= w.command;
    cmd_if.char_code    <= w.char_code;
    cmd_if.position     <= w.position;
    cmd_if.mode_bits    <= w.mode_bits;
    cmd_if.indicator_on <= w.indicator_on;
    cmd_if.key_return   <= w.key_return;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  task automatic tick(logic [1:0] ret);
    send_word(make_word(CMD_TICK, 8'h00, 4'd0, 16'h0000, 1'b0, ret));
  endtask

  task automatic put_char(logic [7:0] ch, logic [3:0] pos);
    send_word(make_word(CMD_PUT_CHAR, ch, pos, 16'h0000, 1'b0, 2'd0));
  endtask

  task automatic mode_cmd(cmd_t c, logic [15:0] mode);
    send_word(make_word(c, 8'h00, 4'd0, mode, 1'b0, 2'd0));
  endtask

  initial begin
    string     char_pool;
    cmd_word_t w;
    int        pick;

    sb = new();
    char_pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 +-.?mogd";
    calm = 1'b0;
    hold_request = 1'b0;

    rst                 <= 1'b1;
    cmd_if.valid        <= 1'b0;
    cmd_if.command      <= CMD_TICK;
    cmd_if.char_code    <= '0;
    cmd_if.position     <= '0;
    cmd_if.mode_bits    <= '0;
    cmd_if.indicator_on <= 1'b0;
    cmd_if.key_return   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first tick sees the blank screen after reset.
    tick(2'd3);
    put_char("A", 4'd0);
    put_char("Z", 4'd1);
    put_char("0", 4'd2);
    put_char("9", 4'd3);
    // A dot after a digit merges into the digit before it.
    put_char(".", 4'd4);
    // A dot at the first position takes that word itself.
    put_char(".", 4'd0);
    put_char("m", 4'd5);
    put_char("?", 4'd6);
    // An unknown code blanks the digit.
    put_char(8'hFF, 4'd7);
    put_char("+", 4'd8);
    // Positions at or past the mode word are ignored.
    put_char("d", 4'd10);
    put_char("A", 4'd15);
    send_word(make_word(CMD_SET_IND, 8'h00, 4'd0, 16'h0000, 1'b1, 2'd0));
    // A character in the indicator's own digit still keeps the dot.
    put_char("o", 4'd9);
    mode_cmd(CMD_SET_MODE, 16'hFFFF);
    mode_cmd(CMD_CLEAR_MODE, 16'h00FF);
    mode_cmd(CMD_OR_MODE, 16'h0001);
    send_word(make_word(CMD_TOGGLE_IND, 8'h00, 4'd0, 16'h0000, 1'b0, 2'd0));
    send_word(make_word(CMD_TOGGLE_IND, 8'h00, 4'd0, 16'h0000, 1'b0, 2'd0));
    tick(2'd1);
    tick(2'd2);
    tick(2'd3);
    // Clear keeps the indicator dot.
    send_word(make_word(CMD_CLEAR, 8'h00, 4'd0, 16'h0000, 1'b0, 2'd0));
    tick(2'd0);

    // Random part: mostly ticks and character writes, so that screens fill up
    // and every digit gets scanned with every return line.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 500 && n < 800);
      if (n == 1100) hold_request = 1'b1;
      w.char_code = ($urandom_range(0, 99) < 75)
                    ? char_pool[$urandom_range(0, char_pool.len() - 1)]
                    : 8'($urandom_range(0, 255));
      w.position = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                                 : 4'($urandom_range(10, 15));
      w.mode_bits    = 16'($urandom);
      w.indicator_on = 1'($urandom);
      w.key_return   = 2'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40)      w.command = CMD_TICK;
      else if (pick < 75) w.command = CMD_PUT_CHAR;
      else if (pick < 79) w.command = CMD_SET_MODE;
      else if (pick < 83) w.command = CMD_OR_MODE;
      else if (pick < 87) w.command = CMD_CLEAR_MODE;
      else if (pick < 91) w.command = CMD_SET_IND;
      else if (pick < 95) w.command = CMD_TOGGLE_IND;
      else                w.command = CMD_CLEAR;
      send_word(w);
    end
    cmd_if.valid <= 1'b0;
    calm = 1'b0;

    // Drain: every expected result, then a short wait for anything stray.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
